// ===== rtl/ppfc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the palette pixel format converter.
// No dependencies.
package ppfc_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
	localparam int IDX_W         = 8;
	localparam int COLOUR_W      = 32;
	localparam int FMT_W         = 4;
	localparam int COUNT_W       = 3;

	// input item modes
	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_CONVERT = 1'b1;

	typedef enum logic [FMT_W-1:0] {
		FMT_X555     = 4'd0,
		FMT_1555     = 4'd1,
		FMT_565      = 4'd2,
		FMT_ARGB4444 = 4'd3,
		FMT_ABGR4444 = 4'd4,
		FMT_RGB24    = 4'd5,
		FMT_BGR24    = 4'd6,
		FMT_RGBA32   = 4'd7,
		FMT_BGRA32   = 4'd8,
		FMT_RGBX32   = 4'd9,
		FMT_BGRX32   = 4'd10
	} fmt_t;

	// Colour leaving the lookup stage towards the packer.
	typedef struct packed {
		logic                valid;
		logic [COLOUR_W-1:0] colour;
	} lut_item_t;

endpackage

// ===== rtl/ppfc_lookup.sv =====
`timescale 1ns / 1ps
// Input register, palette memory and registered palette read (stages 1 and 2).
// Depends on ppfc_pkg.
module ppfc_lookup (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           mode,
	input  logic [ppfc_pkg::IDX_W-1:0]     pixel_index,
	input  logic [ppfc_pkg::COLOUR_W-1:0]  entry_color,
	input  logic                           s3_adv,
	output ppfc_pkg::lut_item_t            item_s2
);
	import ppfc_pkg::*;

	logic [COLOUR_W-1:0] mem [PALETTE_DEPTH];

	logic               v1_s1, v2_s2;
	logic [IDX_W-1:0]   idx_s1;
	logic               hit_s1, hit_s2;
	logic [COLOUR_W-1:0] rd_s2;
	logic               adv1, adv2, accept, in_range;

	assign adv2     = !v2_s2 || s3_adv;
	assign adv1     = !v1_s1 || adv2;
	assign in_stall = !adv1;
	assign accept   = in_valid && adv1;
	assign in_range = {1'b0, pixel_index} < (IDX_W+1)'(PALETTE_DEPTH);

	// palette write, no reset: entries are undefined until loaded
	always_ff @(posedge clk) begin
		if (accept && mode == MODE_LOAD && in_range)
			mem[pixel_index[PAL_AW-1:0]] <= entry_color;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
		end else begin
			if (adv1) v1_s1 <= accept && mode != MODE_LOAD;
			if (adv2) v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			idx_s1 <= pixel_index;
			hit_s1 <= in_range;
		end
		if (adv2 && v1_s1) begin
			rd_s2  <= mem[idx_s1[PAL_AW-1:0]];
			hit_s2 <= hit_s1;
		end
	end

	assign item_s2.valid  = v2_s2;
	assign item_s2.colour = hit_s2 ? rd_s2 : '0;

	// stall only with both stages full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v1_s1 && v2_s2)) else $error("stall with a free stage");

	// accepted convert lands in stage 1
	a_conv_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && mode != MODE_LOAD) |=> v1_s1)
		else $error("convert lost at stage 1");

	// stage 2 holds while the packer is blocked
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_s2 && !s3_adv) |=> (v2_s2 && $stable(rd_s2) && $stable(hit_s2)))
		else $error("stage 2 changed while blocked");

endmodule

// ===== rtl/ppfc_pack.sv =====
`timescale 1ns / 1ps
// Format packer and output register (stage 3).
// Depends on ppfc_pkg.
module ppfc_pack (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ppfc_pkg::lut_item_t            item_s2,
	input  ppfc_pkg::fmt_t                 fmt,
	output logic                           s3_adv,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ppfc_pkg::COLOUR_W-1:0]  packed_pixel,
	output logic [ppfc_pkg::COUNT_W-1:0]   byte_count
);
	import ppfc_pkg::*;

	localparam logic [COUNT_W-1:0] BYTES2 = 3'd2;
	localparam logic [COUNT_W-1:0] BYTES3 = 3'd3;
	localparam logic [COUNT_W-1:0] BYTES4 = 3'd4;

	logic [7:0]          a, r, g, b;
	logic [COLOUR_W-1:0] pk;
	logic [COUNT_W-1:0]  cnt;
	logic                v3_s3;
	logic [COLOUR_W-1:0] pk_s3;
	logic [COUNT_W-1:0]  cnt_s3;

	assign {a, r, g, b} = item_s2.colour;

	always_comb begin
		pk  = '0;
		cnt = BYTES2;
		case (fmt)
			FMT_X555:     pk = {17'd0, r[7:3], g[7:3], b[7:3]};
			FMT_1555:     pk = {16'd0, a[7], r[7:3], g[7:3], b[7:3]};
			FMT_565:      pk = {16'd0, r[7:3], g[7:2], b[7:3]};
			FMT_ARGB4444: pk = {16'd0, a[7:4], r[7:4], g[7:4], b[7:4]};
			FMT_ABGR4444: pk = {16'd0, r[7:4], g[7:4], b[7:4], a[7:4]};
			FMT_RGB24: begin
				pk  = {8'd0, b, g, r};
				cnt = BYTES3;
			end
			FMT_BGR24: begin
				pk  = {8'd0, r, g, b};
				cnt = BYTES3;
			end
			FMT_RGBA32: begin
				pk  = {r, g, b, a};
				cnt = BYTES4;
			end
			FMT_BGRA32: begin
				pk  = {a, r, g, b};
				cnt = BYTES4;
			end
			FMT_RGBX32: begin
				pk  = {r, g, b, 8'hFF};
				cnt = BYTES4;
			end
			FMT_BGRX32: begin
				pk  = {8'hFF, r, g, b};
				cnt = BYTES4;
			end
			default: begin
				pk  = '0;
				cnt = BYTES4;
			end
		endcase
	end

	assign s3_adv = !v3_s3 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v3_s3 <= 1'b0;
		else if (s3_adv) v3_s3 <= item_s2.valid;
	end

	always_ff @(posedge clk) begin
		if (s3_adv && item_s2.valid) begin
			pk_s3  <= pk;
			cnt_s3 <= cnt;
		end
	end

	assign out_valid    = v3_s3;
	assign packed_pixel = pk_s3;
	assign byte_count   = cnt_s3;

	a_block_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s3_adv |-> v3_s3) else $error("stage 3 blocked while empty");

	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		v3_s3 |-> (cnt_s3 == BYTES2 || cnt_s3 == BYTES3 || cnt_s3 == BYTES4))
		else $error("bad byte count");

	a_load_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(s3_adv && item_s2.valid) |=> v3_s3) else $error("item lost at stage 3");

endmodule

// ===== rtl/palette_pixel_format_converter_top.sv =====
`timescale 1ns / 1ps
// Top level of the palette pixel format converter: format register and pipeline.
// Depends on ppfc_pkg, ppfc_lookup and ppfc_pack.
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ----------------------------------
//  input     in         in_valid / in_stall  mode, pixel_index, entry_color
//  result    out        out_valid/out_stall  packed_pixel, byte_count
//  config    in         cfg_valid/cfg_ready  cfg_data (output_format)
//
// One transfer per clock on the input while in_stall is low; a convert's result
// passes the input register, the registered palette read and the output
// register, in that order, before it is presented.
// Loads write the palette at their acceptance edge and give no result.
// Reset clears the valid bits and the format register; palette is not cleared.
// Stalls back-propagate stage by stage, so empty stages still fill under stall.
module palette_pixel_format_converter_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           mode,
	input  logic [ppfc_pkg::IDX_W-1:0]     pixel_index,
	input  logic [ppfc_pkg::COLOUR_W-1:0]  entry_color,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ppfc_pkg::COLOUR_W-1:0]  packed_pixel,
	output logic [ppfc_pkg::COUNT_W-1:0]   byte_count,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ppfc_pkg::FMT_W-1:0]     cfg_data
);
	import ppfc_pkg::*;

	fmt_t      output_format_q;
	lut_item_t item_s2;
	logic      s3_adv;

	// register must only change while idle (not enforced here); it is always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) output_format_q <= FMT_X555;
		else if (cfg_valid && cfg_ready) output_format_q <= fmt_t'(cfg_data);
	end

	// stages 1 and 2: index register and palette read
	ppfc_lookup u_lookup (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.pixel_index (pixel_index),
		.entry_color (entry_color),
		.s3_adv      (s3_adv),
		.item_s2     (item_s2)
	);

	// stage 3: pack and hold the result until transfer
	ppfc_pack u_pack (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_s2      (item_s2),
		.fmt          (output_format_q),
		.s3_adv       (s3_adv),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.packed_pixel (packed_pixel),
		.byte_count   (byte_count)
	);

endmodule
